>>> rtl/core/ctbs_pkg.sv
// Shared types and constants of the CAN transmit buffer scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ctbs_pkg;

  // Field widths fixed by the item format
  localparam int unsigned OP_W     = 2;
  localparam int unsigned BIDX_W   = 4;
  localparam int unsigned IRQ_W    = 2;
  localparam int unsigned DEL_W    = 2;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned NBUF_W   = 5;
  localparam int unsigned SYNC_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SEND     = 2'd0;
  localparam logic [OP_W-1:0] OP_TX_DONE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_SYNC = 2'd2;

  // Interrupt actions
  localparam logic [IRQ_W-1:0] IRQ_NONE    = 2'd0;
  localparam logic [IRQ_W-1:0] IRQ_ENABLE  = 2'd1;
  localparam logic [IRQ_W-1:0] IRQ_DISABLE = 2'd2;

  // Sync deletion codes
  localparam logic [DEL_W-1:0] DEL_NONE    = 2'd0;
  localparam logic [DEL_W-1:0] DEL_INHIBIT = 2'd1;
  localparam logic [DEL_W-1:0] DEL_SYNC    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFERS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MASK      = 2'd1;

  localparam logic [NBUF_W-1:0] NBUF_RESET = 5'd16;

  // What the shared step unit does to each visited buffer
  typedef enum logic [1:0] {
    SCAN_FIRST,
    SCAN_SYNC,
    SCAN_SHRINK
  } scan_mode_e;

  typedef struct packed {
    logic             clear;
    logic             stop;
    logic [CNT_W-1:0] count;
  } step_t;

endpackage

`default_nettype wire

>>> rtl/core/ctbs_if.sv
// Handshake channels of the CAN transmit buffer scheduler: request, response
// and configuration write. Depends on ctbs_pkg.
`default_nettype none

interface ctbs_req_if import ctbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BIDX_W-1:0] buffer_index;
  logic              mailbox_ready;

  modport source (output valid, op, buffer_index, mailbox_ready, input ready);
  modport sink   (input valid, op, buffer_index, mailbox_ready, output ready);
endinterface

interface ctbs_rsp_if import ctbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              overflow;
  logic              overflow_report;
  logic              launch;
  logic [BIDX_W-1:0] launch_index;
  logic [IRQ_W-1:0]  irq_action;
  logic [DEL_W-1:0]  sync_deleted;
  logic [CNT_W-1:0]  pending_total;

  modport source (output valid, overflow, overflow_report, launch, launch_index,
                  irq_action, sync_deleted, pending_total, input ready);
  modport sink   (input valid, overflow, overflow_report, launch, launch_index,
                  irq_action, sync_deleted, pending_total, output ready);
endinterface

interface ctbs_cfg_if import ctbs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ctbs_step_unit.sv
// Shared step unit of the buffer scan: judges one buffer per cycle and
// produces the decremented pending count. Depends on ctbs_pkg.
`default_nettype none

module ctbs_step_unit import ctbs_pkg::*; #(
  parameter int unsigned NW = 5
) (
  input  scan_mode_e       mode_i,
  input  logic             flag_i,
  input  logic             sync_i,
  input  logic [NW-1:0]    ptr_i,
  input  logic [NW-1:0]    active_i,
  input  logic [CNT_W-1:0] count_i,
  output step_t            step_o
);

  logic beyond;

  assign beyond = (ptr_i >= active_i);

  always_comb begin
    step_o = '0;
    case (mode_i)
      SCAN_FIRST: begin
        step_o.clear = flag_i;
        step_o.stop  = flag_i;
      end
      SCAN_SYNC:   step_o.clear = flag_i & sync_i;
      SCAN_SHRINK: step_o.clear = flag_i & beyond;
      default:     step_o = '0;
    endcase
    // saturate at zero, as the count never goes negative
    if (step_o.clear && (count_i != '0)) begin
      step_o.count = count_i - CNT_W'(1);
    end else begin
      step_o.count = count_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/can_tx_buffer_scheduler.sv
// CAN transmit buffer scheduler for one hardware transmit mailbox. A send
// request is decoded on acceptance into the result registers; the result
// moves on into the response register once that register is free. A transmit
// completion with buffers pending, and a clear of pending sync buffers, walk
// the pending flags through one shared step unit, one buffer per cycle: a
// completion stops at the lowest pending buffer, a clear visits all TX_BUFFERS
// entries. Writing buffers_in_use starts a sweep over all TX_BUFFERS entries
// that drops flags beyond the new buffer count; requests are held off until
// it ends. The request channel accepts one transaction at a time; a finished
// result sits in the response register so that the next request can be
// accepted before it is taken.
// Depends on ctbs_pkg, ctbs_if and ctbs_step_unit.
`default_nettype none

module can_tx_buffer_scheduler import ctbs_pkg::*; #(
  parameter int unsigned TX_BUFFERS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  ctbs_req_if.sink    req_i,
  ctbs_rsp_if.source  rsp_o,
  ctbs_cfg_if.sink    cfg_i
);

  // Scan pointer width and the width that holds any buffer count
  localparam int unsigned IW  = (TX_BUFFERS > 1) ? $clog2(TX_BUFFERS) : 1;
  localparam int unsigned NWC = $clog2(TX_BUFFERS + 1);
  localparam int unsigned NW  = (NWC > NBUF_W) ? NWC : NBUF_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Control state
  logic [1:0]            state_q, state_d;
  scan_mode_e            mode_q, mode_d;
  logic [IW-1:0]         ptr_q, ptr_d;
  logic [TX_BUFFERS-1:0] flags_q, flags_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  bootup_q, bootup_d;
  logic                  inhibit_q, inhibit_d;
  logic [NBUF_W-1:0]     nbuf_q, nbuf_d;
  logic [SYNC_W-1:0]     sync_q, sync_d;
  logic                  out_valid_q, out_valid_d;

  // Result being built, then the response register
  logic                  res_ovf_q, res_ovf_d;
  logic                  res_rep_q, res_rep_d;
  logic                  res_launch_q, res_launch_d;
  logic [BIDX_W-1:0]     res_lidx_q, res_lidx_d;
  logic [IRQ_W-1:0]      res_irq_q, res_irq_d;
  logic [DEL_W-1:0]      res_del_q, res_del_d;

  logic                  out_ovf_q, out_rep_q, out_launch_q;
  logic [BIDX_W-1:0]     out_lidx_q;
  logic [IRQ_W-1:0]      out_irq_q;
  logic [DEL_W-1:0]      out_del_q;
  logic [CNT_W-1:0]      out_cnt_q;

  logic                  req_fire, cfg_fire, push;
  logic [NW-1:0]         active, nbuf_ext, ptr_ext, idx_ext;
  logic [IW-1:0]         sel_idx;
  logic                  idx_in_range, idx_pending, ptr_sync, ptr_last;
  step_t                 step;

  // Effective buffer count: values above TX_BUFFERS act as TX_BUFFERS
  assign nbuf_ext = NW'(nbuf_q);
  assign active   = (nbuf_ext > NW'(TX_BUFFERS)) ? NW'(TX_BUFFERS) : nbuf_ext;

  assign idx_ext      = NW'(req_i.buffer_index);
  assign sel_idx      = idx_ext[IW-1:0];
  assign idx_in_range = (idx_ext < active);
  assign idx_pending  = idx_in_range && flags_q[sel_idx];

  assign ptr_ext  = NW'(ptr_q);
  assign ptr_sync = (ptr_ext < NW'(SYNC_W)) && sync_q[ptr_ext[BIDX_W-1:0]];
  assign ptr_last = (ptr_q == IW'(TX_BUFFERS - 1));

  ctbs_step_unit #(
    .NW (NW)
  ) u_step (
    .mode_i   (mode_q),
    .flag_i   (flags_q[ptr_q]),
    .sync_i   (ptr_sync),
    .ptr_i    (ptr_ext),
    .active_i (active),
    .count_i  (count_q),
    .step_o   (step)
  );

  // Accept requests and register writes only between transactions
  assign req_i.ready = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  // Hand the result over once the response register is free
  assign push = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    ptr_d        = ptr_q;
    flags_d      = flags_q;
    count_d      = count_q;
    bootup_d     = bootup_q;
    inhibit_d    = inhibit_q;
    nbuf_d       = nbuf_q;
    sync_d       = sync_q;
    res_ovf_d    = res_ovf_q;
    res_rep_d    = res_rep_q;
    res_launch_d = res_launch_q;
    res_lidx_d   = res_lidx_q;
    res_irq_d    = res_irq_q;
    res_del_d    = res_del_q;

    case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          case (cfg_i.index)
            CFG_BUFFERS_IN_USE: begin
              nbuf_d  = cfg_i.data[NBUF_W-1:0];
              mode_d  = SCAN_SHRINK;
              ptr_d   = '0;
              state_d = ST_SCAN;
            end
            CFG_SYNC_MASK: sync_d = cfg_i.data[SYNC_W-1:0];
            default: ;
          endcase
        end else if (req_fire) begin
          res_ovf_d    = 1'b0;
          res_rep_d    = 1'b0;
          res_launch_d = 1'b0;
          res_lidx_d   = '0;
          res_irq_d    = IRQ_NONE;
          res_del_d    = DEL_NONE;
          ptr_d        = '0;
          state_d      = ST_DONE;
          case (req_i.op)
            OP_SEND: begin
              if (idx_in_range) begin
                res_ovf_d = idx_pending;
                res_rep_d = idx_pending && !bootup_q;
                res_irq_d = IRQ_ENABLE;
                if (req_i.mailbox_ready && (count_q == '0)) begin
                  // launch straight away; inhibit follows the buffer's sync bit
                  inhibit_d    = sync_q[req_i.buffer_index];
                  res_launch_d = 1'b1;
                  res_lidx_d   = req_i.buffer_index;
                end else if (!idx_pending) begin
                  flags_d[sel_idx] = 1'b1;
                  count_d          = count_q + CNT_W'(1);
                end
              end
            end
            OP_TX_DONE: begin
              bootup_d  = 1'b0;
              inhibit_d = 1'b0;
              if (count_q != '0) begin
                mode_d  = SCAN_FIRST;
                state_d = ST_SCAN;
              end else begin
                res_irq_d = IRQ_DISABLE;
              end
            end
            OP_CLR_SYNC: begin
              if (inhibit_q) begin
                inhibit_d = 1'b0;
                res_del_d = DEL_INHIBIT;
              end
              if (count_q != '0) begin
                mode_d  = SCAN_SYNC;
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        count_d = step.count;
        if (step.clear) begin
          flags_d[ptr_q] = 1'b0;
          if (mode_q == SCAN_SYNC) begin
            res_del_d = DEL_SYNC;
          end
        end
        if (step.stop) begin
          res_launch_d = 1'b1;
          res_lidx_d   = ptr_ext[BIDX_W-1:0];
        end
        if (step.stop || ptr_last) begin
          state_d = (mode_q == SCAN_SHRINK) ? ST_IDLE : ST_DONE;
          // a completion that finds nothing pending drops the stale count
          if ((mode_q == SCAN_FIRST) && !step.stop) begin
            count_d = '0;
          end
        end else begin
          ptr_d = ptr_q + IW'(1);
        end
      end

      ST_DONE: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= SCAN_FIRST;
      ptr_q       <= '0;
      flags_q     <= '0;
      count_q     <= '0;
      bootup_q    <= 1'b1;
      inhibit_q   <= 1'b0;
      nbuf_q      <= NBUF_RESET;
      sync_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      ptr_q       <= ptr_d;
      flags_q     <= flags_d;
      count_q     <= count_d;
      bootup_q    <= bootup_d;
      inhibit_q   <= inhibit_d;
      nbuf_q      <= nbuf_d;
      sync_q      <= sync_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    res_ovf_q    <= res_ovf_d;
    res_rep_q    <= res_rep_d;
    res_launch_q <= res_launch_d;
    res_lidx_q   <= res_lidx_d;
    res_irq_q    <= res_irq_d;
    res_del_q    <= res_del_d;
    if (push) begin
      out_ovf_q    <= res_ovf_q;
      out_rep_q    <= res_rep_q;
      out_launch_q <= res_launch_q;
      out_lidx_q   <= res_lidx_q;
      out_irq_q    <= res_irq_q;
      out_del_q    <= res_del_q;
      out_cnt_q    <= count_q;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.overflow        = out_ovf_q;
  assign rsp_o.overflow_report = out_rep_q;
  assign rsp_o.launch          = out_launch_q;
  assign rsp_o.launch_index    = out_lidx_q;
  assign rsp_o.irq_action      = out_irq_q;
  assign rsp_o.sync_deleted    = out_del_q;
  assign rsp_o.pending_total   = out_cnt_q;

endmodule

`default_nettype wire
